// ----- hw/rtl/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants for the spectrogram column colormap
// Item format, control codes, divider sizing and palette tables.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_BINS_DEF   = 256;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Divider: numerator, divisor and quotient widths. Every quotient is
  // known to be below 2^DIV_QW, so only DIV_QW steps are needed.
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 33;
  localparam int DIV_QW = 17;

  localparam logic [16:0] U_ONE = 17'd65536;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_FETCH = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_STYLE  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    STYLE_MEL  = 2'd0,
    STYLE_HOT  = 2'd1,
    STYLE_MFCC = 2'd2,
    STYLE_ALT  = 2'd3
  } style_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic               last;
    logic [9:0]         row;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX_MUL,
    ST_IDX_GO,
    ST_IDX_DIV,
    ST_READ,
    ST_VAL,
    ST_VAL_GO,
    ST_VAL_DIV,
    ST_PAL,
    ST_MIX,
    ST_EMIT
  } state_t;

  // Palette stop k (0..5) of a style; styles 2 and 3 use the diverging palette.
  function automatic logic [23:0] pal_color(logic [1:0] style, logic [2:0] k);
    logic [23:0] c;
    c = 24'h000000;
    case (style)
      STYLE_MEL: begin
        case (k)
          3'd0:    c = 24'h020617;
          3'd1:    c = 24'h064E3B;
          3'd2:    c = 24'h22C55E;
          3'd3:    c = 24'hFACC15;
          default: c = 24'hFFF7AE;
        endcase
      end
      STYLE_HOT: begin
        case (k)
          3'd0:    c = 24'h050505;
          3'd1:    c = 24'h3B0A45;
          3'd2:    c = 24'h9D174D;
          3'd3:    c = 24'hF97316;
          3'd4:    c = 24'hFACC15;
          default: c = 24'hFFF7AE;
        endcase
      end
      default: begin
        case (k)
          3'd0:    c = 24'h1E3A8A;
          3'd1:    c = 24'h2563EB;
          3'd2:    c = 24'h111827;
          3'd3:    c = 24'hF97316;
          default: c = 24'hFACC15;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/spectrogram_column_colormap.sv -----
// ----------------------------------------------------------------------------
// spectrogram_column_colormap: min/max or zero-centred normalized heatmap for one column
// Loads a spectrogram column and returns palette colors for pixel rows.
// ----------------------------------------------------------------------------
// A load transaction (tuser=0) stores one Q15.16 value and tracks min, max and
// largest magnitude; tlast closes the column, values past MAX_BINS are dropped
// and a load after a closed column starts a new one. A fetch transaction
// (tuser=1) maps its row to bin floor((h-1-row)*(count-1)/h), normalizes the
// value (min/max, or around zero for the diverging style) and blends two
// palette stops. A load is applied as the execution side pops it from the
// queue while idle. A fetch takes a multiply, an index pass of one shared
// radix-2 divider, a store read, a value pass of the divider, then palette
// and mix stages before its result goes out; an early fetch or a row outside
// the height returns a result with tuser=0 and black. A four-entry queue sits
// between input and execution and a result register sits on the output, so
// inputs keep flowing while a result waits, until the queue fills.
// Configuration must be written only while idle; the block does not enforce
// it. Column store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module spectrogram_column_colormap #(
  parameter int MAX_BINS   = scc_pkg::MAX_BINS_DEF,
  parameter int MAX_HEIGHT = scc_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] sample_value, [41:32] row, zero fill
  input  logic        s_tlast,   // last
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_tuser,   // valid_res
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  logic [1:0]  colour_style;
  logic [10:0] image_height;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      colour_style <= scc_pkg::STYLE_MEL;
      image_height <= 11'd320;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scc_pkg::CFG_STYLE:  colour_style <= cfg_data[1:0];
        scc_pkg::CFG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify and unpack the transaction into a queue item
  scc_pkg::item_t in_item;
  scc_pkg::item_t q_item;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           push;

  assign in_item.kind  = s_tuser ? scc_pkg::KIND_FETCH : scc_pkg::KIND_LOAD;
  assign in_item.value = s_tdata[31:0];
  assign in_item.last  = s_tlast;
  assign in_item.row   = s_tdata[41:32];
  assign s_tready      = !q_full;
  assign push          = s_tvalid && !q_full;

  scc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  // Back: execution and result register
  scc_back #(
    .MAX_BINS   (MAX_BINS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .colour_style (colour_style),
    .image_height (image_height),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_flag     (m_tuser),
    .out_rgb      (m_tdata)
  );

endmodule

// ----- hw/rtl/scc_queue.sv -----
// ----------------------------------------------------------------------------
// scc_queue: short item queue between front and back
// Small register FIFO; either side stalls independently.
// ----------------------------------------------------------------------------
module scc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output scc_pkg::item_t pop_item,
  output logic           not_empty
);

  localparam int AW = scc_pkg::QUEUE_AW;
  localparam int CW = $clog2(scc_pkg::QUEUE_DEPTH + 1);

  scc_pkg::item_t slots [scc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;

  assign full      = (fill == CW'(scc_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop)      fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

endmodule

// ----- hw/rtl/scc_div.sv -----
// ----------------------------------------------------------------------------
// scc_div: iterative restoring divider
// One quotient bit per cycle; quotient must fit DIV_QW bits.
// ----------------------------------------------------------------------------
module scc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [scc_pkg::DIV_NW-1:0]  num,
  input  logic [scc_pkg::DIV_DW-1:0]  den,
  output logic                        busy,
  output logic                        done,
  output logic [scc_pkg::DIV_QW-1:0]  quo
);

  localparam int NW = scc_pkg::DIV_NW;
  localparam int DW = scc_pkg::DIV_DW;
  localparam int QW = scc_pkg::DIV_QW;
  localparam int RW = DW + 1;
  localparam int KW = $clog2(QW + 1);

  logic [RW-1:0] rem;
  logic [QW-1:0] nsh;
  logic [DW-1:0] den_q;
  logic [KW-1:0] cnt;
  logic [RW-1:0] trial;
  logic          fits;

  assign trial = {rem[RW-2:0], nsh[QW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KW'(QW);
      end else if (busy) begin
        cnt <= cnt - KW'(1);
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= RW'(num[NW-1:QW]);
      nsh   <= num[QW-1:0];
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, den_q}) : trial;
      nsh <= {nsh[QW-2:0], 1'b0};
      quo <= {quo[QW-2:0], fits};
    end
  end

endmodule

// ----- hw/rtl/scc_back.sv -----
// ----------------------------------------------------------------------------
// scc_back: column store, statistics and pixel pipeline
// Executes loads and fetches from the queue; owns the output register.
// ----------------------------------------------------------------------------
module scc_back #(
  parameter int MAX_BINS   = scc_pkg::MAX_BINS_DEF,
  parameter int MAX_HEIGHT = scc_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  scc_pkg::item_t q_item,
  output logic           q_pop,
  input  logic [1:0]     colour_style,
  input  logic [10:0]    image_height,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_flag,
  output logic [23:0]    out_rgb
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int PW = 11 + CW;

  scc_pkg::state_t state, state_next;

  logic signed [31:0] store [MAX_BINS];
  logic [CW-1:0]      bin_count;
  logic signed [31:0] column_min;
  logic signed [31:0] column_max;
  logic [31:0]        column_max_abs;
  logic               column_ready;

  logic [9:0]                   row_q;
  logic [AW-1:0]                idx;
  logic signed [31:0]           val;
  logic [scc_pkg::DIV_NW-1:0]   div_num;
  logic [scc_pkg::DIV_DW-1:0]   div_den;
  logic                         div_start;
  logic                         div_busy;
  logic                         div_done;
  logic [scc_pkg::DIV_QW-1:0]   div_quo;
  logic [16:0]                  u;
  logic [2:0]                   seg;
  logic [16:0]                  t;
  logic                         res_flag;
  logic [23:0]                  res_rgb;

  // Fetch geometry
  logic [10:0]        h;
  logic               fetch_ok;
  logic [CW-1:0]      load_base;
  logic [31:0]        mag;
  logic               out_free;

  assign h = (13'(image_height) > 13'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : image_height;
  assign fetch_ok  = column_ready && (bin_count != '0) && ({1'b0, q_item.row} < h);
  assign load_base = column_ready ? '0 : bin_count;
  assign mag       = q_item.value[31] ? (32'd0 - q_item.value) : q_item.value;
  assign out_free  = !out_valid || out_ready;

  scc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= scc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      scc_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == scc_pkg::KIND_FETCH) begin
            state_next = fetch_ok ? scc_pkg::ST_IDX_MUL : scc_pkg::ST_EMIT;
          end
        end
      end
      scc_pkg::ST_IDX_MUL: state_next = scc_pkg::ST_IDX_GO;
      scc_pkg::ST_IDX_GO: begin
        div_start  = 1'b1;
        state_next = scc_pkg::ST_IDX_DIV;
      end
      scc_pkg::ST_IDX_DIV: if (div_done) state_next = scc_pkg::ST_READ;
      scc_pkg::ST_READ:    state_next = scc_pkg::ST_VAL;
      scc_pkg::ST_VAL:     state_next = scc_pkg::ST_VAL_GO;
      scc_pkg::ST_VAL_GO: begin
        div_start  = 1'b1;
        state_next = scc_pkg::ST_VAL_DIV;
      end
      scc_pkg::ST_VAL_DIV: if (div_done) state_next = scc_pkg::ST_PAL;
      scc_pkg::ST_PAL:     state_next = scc_pkg::ST_MIX;
      scc_pkg::ST_MIX:     state_next = scc_pkg::ST_EMIT;
      scc_pkg::ST_EMIT:    if (out_free) state_next = scc_pkg::ST_IDLE;
      default:             state_next = scc_pkg::ST_IDLE;
    endcase
  end

  // Column store: one write port (load), one registered read port (fetch)
  always_ff @(posedge clk) begin
    if (state == scc_pkg::ST_IDLE && q_valid && q_item.kind == scc_pkg::KIND_LOAD &&
        load_base < CW'(MAX_BINS)) begin
      store[load_base[AW-1:0]] <= q_item.value;
    end
    if (state == scc_pkg::ST_READ) begin
      val <= store[idx];
    end
  end

  // Column statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count      <= '0;
      column_min     <= '0;
      column_max     <= '0;
      column_max_abs <= '0;
      column_ready   <= 1'b0;
    end else if (state == scc_pkg::ST_IDLE && q_valid &&
                 q_item.kind == scc_pkg::KIND_LOAD) begin
      column_ready <= q_item.last;
      bin_count    <= load_base;
      if (load_base < CW'(MAX_BINS)) begin
        bin_count <= load_base + CW'(1);
        if (load_base == '0) begin
          column_min     <= q_item.value;
          column_max     <= q_item.value;
          column_max_abs <= mag;
        end else begin
          if (q_item.value < column_min) column_min <= q_item.value;
          if (q_item.value > column_max) column_max <= q_item.value;
          if (mag > column_max_abs)      column_max_abs <= mag;
        end
      end
    end
  end

  // Pixel datapath
  logic [10:0]          rows_up;
  logic [CW-1:0]        cnt_m1;
  logic [PW-1:0]        idx_prod;
  logic signed [32:0]   diff;
  logic [32:0]          range;
  logic [31:0]          m_abs;
  logic signed [33:0]   shifted;
  logic                 diverging;
  logic [19:0]          scaled;
  logic [2:0]           seg_max;
  logic [2:0]           seg_raw;
  logic [16:0]          t_raw;
  logic [23:0]          col_a;
  logic [23:0]          col_b;
  logic [23:0]          mix;

  assign rows_up   = h - 11'(row_q) - 11'd1;
  assign cnt_m1    = bin_count - CW'(1);
  assign idx_prod  = PW'(rows_up) * PW'(cnt_m1);
  assign diff      = 33'(val) - 33'(column_min);
  assign range     = 33'(column_max) - 33'(column_min);
  assign m_abs     = (column_max_abs == '0) ? 32'd1 : column_max_abs;
  assign shifted   = 34'(val) + $signed({2'b00, m_abs});
  assign diverging = colour_style[1];
  assign scaled    = 20'(u) * ((colour_style == scc_pkg::STYLE_HOT) ? 20'd5 : 20'd4);
  assign seg_max   = (colour_style == scc_pkg::STYLE_HOT) ? 3'd4 : 3'd3;
  assign seg_raw   = (scaled[19:16] > 4'(seg_max)) ? seg_max : scaled[18:16];
  assign t_raw     = 17'(scaled - {1'b0, seg_raw, 16'd0});
  assign col_a     = scc_pkg::pal_color(colour_style, seg);
  assign col_b     = scc_pkg::pal_color(colour_style, seg + 3'd1);

  // Channel = a + (b - a) * t / 2^16, floored; sum stays in 0 .. 255 * 2^16.
  // Palette words are RRGGBB; output lane c=0 is red, so it takes bits 23:16.
  for (genvar c = 0; c < 3; c++) begin : g_mix
    logic signed [26:0] delta;
    logic signed [26:0] tt;
    logic signed [26:0] acc;
    assign delta = 27'($signed({1'b0, col_b[8*(2-c) +: 8]}))
                 - 27'($signed({1'b0, col_a[8*(2-c) +: 8]}));
    assign tt    = $signed({10'd0, t});
    assign acc   = $signed({3'd0, col_a[8*(2-c) +: 8], 16'd0}) + delta * tt;
    assign mix[8*c +: 8] = acc[23:16];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      scc_pkg::ST_IDLE: begin
        row_q    <= q_item.row;
        res_flag <= 1'b0;
        res_rgb  <= '0;
      end
      scc_pkg::ST_IDX_MUL: begin
        div_num <= scc_pkg::DIV_NW'(idx_prod);
        div_den <= scc_pkg::DIV_DW'(h);
      end
      scc_pkg::ST_IDX_DIV: begin
        if (div_done) begin
          idx <= (div_quo >= scc_pkg::DIV_QW'(bin_count)) ? cnt_m1[AW-1:0]
                                                           : div_quo[AW-1:0];
        end
      end
      scc_pkg::ST_VAL: begin
        u <= '0;
        if (diverging) begin
          div_num <= scc_pkg::DIV_NW'({shifted[32:0], 15'd0});
          div_den <= scc_pkg::DIV_DW'(m_abs);
        end else begin
          div_num <= scc_pkg::DIV_NW'({diff[31:0], 16'd0});
          div_den <= range;
        end
      end
      scc_pkg::ST_VAL_DIV: begin
        if (div_done) begin
          if ((diverging && shifted < 0) ||
              (!diverging && (range == '0 || val <= column_min))) begin
            u <= '0;
          end else if (div_quo > scc_pkg::U_ONE) begin
            u <= scc_pkg::U_ONE;
          end else begin
            u <= div_quo;
          end
        end
      end
      scc_pkg::ST_PAL: begin
        seg <= seg_raw;
        t   <= (t_raw > scc_pkg::U_ONE) ? scc_pkg::U_ONE : t_raw;
      end
      scc_pkg::ST_MIX: begin
        res_flag <= 1'b1;
        res_rgb  <= mix;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == scc_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == scc_pkg::ST_EMIT && out_free) begin
      out_flag <= res_flag;
      out_rgb  <= res_rgb;
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_bin_count_bound: assert property (@(posedge clk) disable iff (rst)
    bin_count <= CW'(MAX_BINS)) else $error("bin count past store depth");

  a_u_range: assert property (@(posedge clk) disable iff (rst)
    state == scc_pkg::ST_PAL |-> u <= scc_pkg::U_ONE) else $error("fraction above one");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == scc_pkg::ST_IDLE || state == scc_pkg::ST_IDX_MUL ||
              state == scc_pkg::ST_EMIT) else $error("bad state after pop");

endmodule
